/* hdl/sm83alu_pkg.sv */
`default_nettype none

package sm83alu_pkg;

    typedef enum logic [3:0] {
        MODE_ADD   = 4'd0,
        MODE_ADC   = 4'd1,
        MODE_SUB   = 4'd2,
        MODE_SBC   = 4'd3,
        MODE_AND   = 4'd4,
        MODE_OR    = 4'd5,
        MODE_XOR   = 4'd6,
        MODE_CP    = 4'd7,
        MODE_INC8  = 4'd8,
        MODE_DEC8  = 4'd9,
        MODE_ADD16 = 4'd10,
        MODE_ADDSP = 4'd11,
        MODE_INC16 = 4'd12,
        MODE_DEC16 = 4'd13
    } alu_mode_t;

    typedef struct packed {
        alu_mode_t   mode;
        logic [15:0] first_operand;
        logic [15:0] second_operand;
    } alu_in_t;

    typedef struct packed {
        logic [15:0] result;
        logic        write_back;
        logic        zero_flag;
        logic        subtract_flag;
        logic        half_carry_flag;
        logic        carry_flag;
    } alu_out_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } alu_flags_t;

    localparam alu_flags_t FLAGS_CLEAR = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

`default_nettype wire

/* hdl/sm83_alu_with_flags.sv */
// SM83-style 8-bit ALU with a kept Z/N/H/C flag register. Each input transaction carries
// an operation code and two 16-bit operands and yields exactly one result transaction
// with the result, a write-back strobe and the flags after the operation. An operation
// is captured in an input register, evaluated by one pass of combinational logic and
// held in an output register until taken. The flag register updates as an operation
// moves into the output register, so ADC, SBC and the flag-keeping operations see the
// flags of the operation before. One transaction per cycle is sustained while the output
// is not stalled. An accepted transaction passes through the input register and then the
// output register, which raises m_valid; while the output stalls, the result is held
// there. Flags reset to zero.
`default_nettype none

module sm83_alu_with_flags (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  var sm83alu_pkg::alu_in_t s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output sm83alu_pkg::alu_out_t  m_data
);
    import sm83alu_pkg::*;

    logic       in_valid_reg;
    alu_in_t    in_data_reg;
    logic       out_valid_reg;
    alu_out_t   out_data_reg;
    alu_flags_t flags_reg;
    alu_flags_t flags_next;
    alu_out_t   out_data_next;
    logic       advance;

    sm83alu_core u_core (
        .op_in     (in_data_reg),
        .flags_in  (flags_reg),
        .op_out    (out_data_next),
        .flags_out (flags_next)
    );

    // The input register hands over whenever the output register is empty or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= FLAGS_CLEAR;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/sm83alu_core.sv */
`default_nettype none

module sm83alu_core (
    input  var sm83alu_pkg::alu_in_t    op_in,
    input  var sm83alu_pkg::alu_flags_t flags_in,
    output sm83alu_pkg::alu_out_t       op_out,
    output sm83alu_pkg::alu_flags_t     flags_out
);
    import sm83alu_pkg::*;

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [15:0] a16;
    logic [15:0] b16;
    logic        cin_add;
    logic        cin_sub;
    logic [8:0]  add9;
    logic [4:0]  add_nib;
    logic [8:0]  sub9;
    logic [4:0]  sub_nib;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] add17;
    logic [12:0] add13;
    logic [15:0] sp_sum;
    logic [8:0]  sp9;
    logic [4:0]  sp_nib;
    logic [7:0]  logic8;
    logic [15:0] res;
    logic        wb;
    alu_flags_t  f;

    assign a8  = op_in.first_operand[7:0];
    assign b8  = op_in.second_operand[7:0];
    assign a16 = op_in.first_operand;
    assign b16 = op_in.second_operand;

    // ADC and SBC take the kept carry; the plain forms and CP do not.
    assign cin_add = (op_in.mode == MODE_ADC) ? flags_in.c : 1'b0;
    assign cin_sub = (op_in.mode == MODE_SBC) ? flags_in.c : 1'b0;

    assign add9    = {1'b0, a8} + {1'b0, b8} + {8'd0, cin_add};
    assign add_nib = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin_add};
    // Bit 8 and bit 4 of the differences are the borrows out of the byte and nibble.
    assign sub9    = {1'b0, a8} - {1'b0, b8} - {8'd0, cin_sub};
    assign sub_nib = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin_sub};
    assign inc8    = a8 + 8'd1;
    assign dec8    = a8 - 8'd1;
    assign add17   = {1'b0, a16} + {1'b0, b16};
    assign add13   = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
    assign sp_sum  = a16 + {{8{b8[7]}}, b8};
    assign sp9     = {1'b0, a8} + {1'b0, b8};
    assign sp_nib  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};

    always_comb begin
        res    = 16'd0;
        wb     = 1'b1;
        f      = flags_in;
        logic8 = 8'd0;
        unique case (op_in.mode) inside
            MODE_ADD, MODE_ADC: begin
                res = {8'd0, add9[7:0]};
                f   = '{z: (add9[7:0] == 8'd0), n: 1'b0, h: add_nib[4], c: add9[8]};
            end
            MODE_SUB, MODE_SBC, MODE_CP: begin
                res = {8'd0, sub9[7:0]};
                wb  = (op_in.mode != MODE_CP);
                f   = '{z: (sub9[7:0] == 8'd0), n: 1'b1, h: sub_nib[4], c: sub9[8]};
            end
            MODE_AND, MODE_OR, MODE_XOR: begin
                if (op_in.mode == MODE_AND) begin
                    logic8 = a8 & b8;
                end else if (op_in.mode == MODE_OR) begin
                    logic8 = a8 | b8;
                end else begin
                    logic8 = a8 ^ b8;
                end
                res = {8'd0, logic8};
                f   = '{z: (logic8 == 8'd0), n: 1'b0, h: (op_in.mode == MODE_AND),
                        c: 1'b0};
            end
            MODE_INC8: begin
                res = {8'd0, inc8};
                f   = '{z: (inc8 == 8'd0), n: 1'b0, h: (a8[3:0] == 4'hF), c: flags_in.c};
            end
            MODE_DEC8: begin
                res = {8'd0, dec8};
                f   = '{z: (dec8 == 8'd0), n: 1'b1, h: (a8[3:0] == 4'h0), c: flags_in.c};
            end
            MODE_ADD16: begin
                res = add17[15:0];
                f   = '{z: flags_in.z, n: 1'b0, h: add13[12], c: add17[16]};
            end
            MODE_ADDSP: begin
                res = sp_sum;
                f   = '{z: 1'b0, n: 1'b0, h: sp_nib[4], c: sp9[8]};
            end
            MODE_INC16: begin
                res = a16 + 16'd1;
            end
            MODE_DEC16: begin
                res = a16 - 16'd1;
            end
            default: begin
                res = 16'd0;
                wb  = 1'b0;
            end
        endcase
    end

    assign flags_out = f;
    assign op_out    = '{result: res, write_back: wb, zero_flag: f.z,
                         subtract_flag: f.n, half_carry_flag: f.h, carry_flag: f.c};

endmodule

`default_nettype wire

/* hdl/sm83alu_checker.sv */
`default_nettype none

module sm83alu_checker (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire                      m_valid,
    input wire                      m_ready,
    input var sm83alu_pkg::alu_out_t m_data
);
    import sm83alu_pkg::*;

    // A stalled result transaction holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With nothing waiting at the output, the input side is never stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // An accepted transaction is expected at the output once it has passed the input and output registers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> ##1 m_valid)
        else $error("accepted transaction did not reach the output");

    // A result without write-back comes from a compare or an undefined code, so its
    // high byte is always zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.write_back && m_data.result[15:8] != 8'd0 |-> 1'b0)
        else $error("non-written result has a high byte");

endmodule

bind sm83_alu_with_flags sm83alu_checker u_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
    import sm83alu_pkg::*;

    // Codes past the last defined operation; the ALU must treat them as no-ops.
    localparam alu_mode_t MODE_RSVD_E = alu_mode_t'(4'd14);
    localparam alu_mode_t MODE_RSVD_F = alu_mode_t'(4'd15);
    localparam int RANDOM_OPS = 800;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    alu_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    alu_out_t m_data;

    alu_in_t    op_queue[$];
    alu_out_t   expected_results[$];
    alu_flags_t kept_flags = FLAGS_CLEAR;
    logic       s_fire = 1'b0;
    int         send_idle_pct = 37;
    int         recv_stall_pct = 54;
    int         ops_accepted = 0;
    int         results_checked = 0;
    int         error_count = 0;
    int         cycle_count = 0;

    sm83_alu_with_flags uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Computes the result of one operation and advances the kept flags.
    function automatic alu_out_t predict_alu(input alu_in_t op);
        logic [15:0] a16;
        logic [15:0] b16;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  r8;
        logic        cin;
        logic [8:0]  wide8;
        logic [4:0]  nib;
        logic [16:0] sum17;
        logic [12:0] sum13;
        alu_flags_t  f;
        alu_out_t    res;
        a16 = op.first_operand;
        b16 = op.second_operand;
        a = a16[7:0];
        b = b16[7:0];
        cin = kept_flags.c;
        f = kept_flags;
        res = '0;
        res.write_back = 1'b1;
        case (op.mode)
            MODE_ADD, MODE_ADC: begin
                if (op.mode == MODE_ADD) cin = 1'b0;
                wide8 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
                nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
                res.result = {8'h00, wide8[7:0]};
                f.z = (wide8[7:0] == 8'h00);
                f.n = 1'b0;
                f.h = nib[4];
                f.c = wide8[8];
            end
            MODE_SUB, MODE_SBC, MODE_CP: begin
                if (op.mode != MODE_SBC) cin = 1'b0;
                // The sign bit of the widened difference is the borrow.
                wide8 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
                nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
                res.result = {8'h00, wide8[7:0]};
                f.z = (wide8[7:0] == 8'h00);
                f.n = 1'b1;
                f.h = nib[4];
                f.c = wide8[8];
                if (op.mode == MODE_CP) res.write_back = 1'b0;
            end
            MODE_AND, MODE_OR, MODE_XOR: begin
                if (op.mode == MODE_AND) r8 = a & b;
                else if (op.mode == MODE_OR) r8 = a | b;
                else r8 = a ^ b;
                res.result = {8'h00, r8};
                f.z = (r8 == 8'h00);
                f.n = 1'b0;
                f.h = (op.mode == MODE_AND);
                f.c = 1'b0;
            end
            MODE_INC8: begin
                r8 = a + 8'd1;
                res.result = {8'h00, r8};
                f.z = (r8 == 8'h00);
                f.n = 1'b0;
                f.h = (a[3:0] == 4'hF);
            end
            MODE_DEC8: begin
                r8 = a - 8'd1;
                res.result = {8'h00, r8};
                f.z = (r8 == 8'h00);
                f.n = 1'b1;
                f.h = (a[3:0] == 4'h0);
            end
            MODE_ADD16: begin
                sum17 = {1'b0, a16} + {1'b0, b16};
                sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
                res.result = sum17[15:0];
                f.n = 1'b0;
                f.h = sum13[12];
                f.c = sum17[16];
            end
            MODE_ADDSP: begin
                // Flags come from the unsigned low-byte add, not the signed word add.
                res.result = a16 + {{8{b[7]}}, b};
                wide8 = {1'b0, a} + {1'b0, b};
                nib = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                f.z = 1'b0;
                f.n = 1'b0;
                f.h = nib[4];
                f.c = wide8[8];
            end
            MODE_INC16: res.result = a16 + 16'd1;
            MODE_DEC16: res.result = a16 - 16'd1;
            default: begin
                res.result = 16'h0000;
                res.write_back = 1'b0;
            end
        endcase
        kept_flags = f;
        res.zero_flag = f.z;
        res.subtract_flag = f.n;
        res.half_carry_flag = f.h;
        res.carry_flag = f.c;
        return res;
    endfunction

    task automatic queue_op(input alu_mode_t m, input logic [15:0] a, input logic [15:0] b);
        alu_in_t op;
        op.mode = m;
        op.first_operand = a;
        op.second_operand = b;
        op_queue.push_back(op);
    endtask

    // Biases operands toward the boundaries where carries and borrows flip.
    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(9))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v[7:0] = 8'hFF;
            3: v[3:0] = 4'hF;
            4: v[3:0] = 4'h0;
            5: v[11:0] = 12'hFFF;
            6: v[7:0] = 8'h80;
            default: ;
        endcase
        return v;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Driver: presents transactions at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data <= op_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Input side: every accepted operation yields one expected result.
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(predict_alu(s_data));
            ops_accepted++;
        end
    end

    // Monitor: compares each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        alu_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no operation outstanding: %0h", m_data);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("result", want.result, m_data.result);
                check_field("write_back", want.write_back, m_data.write_back);
                check_field("zero_flag", want.zero_flag, m_data.zero_flag);
                check_field("subtract_flag", want.subtract_flag, m_data.subtract_flag);
                check_field("half_carry_flag", want.half_carry_flag,
                            m_data.half_carry_flag);
                check_field("carry_flag", want.carry_flag, m_data.carry_flag);
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int total_ops;
        alu_mode_t m;

        // Carry chains: add sets carry, adc consumes it, sub borrows, sbc consumes it.
        queue_op(MODE_ADD, 16'h00FF, 16'h0001);
        queue_op(MODE_ADC, 16'h000E, 16'h0001);
        queue_op(MODE_ADD, 16'hAB0F, 16'hCD01);
        queue_op(MODE_ADC, 16'h00FF, 16'h00FF);
        queue_op(MODE_SUB, 16'h0000, 16'h0001);
        queue_op(MODE_SBC, 16'h0010, 16'h000F);
        queue_op(MODE_SBC, 16'hFF00, 16'hFFFF);
        queue_op(MODE_AND, 16'h00F0, 16'h000F);
        queue_op(MODE_OR, 16'hFF00, 16'h0000);
        queue_op(MODE_XOR, 16'h12A5, 16'h34A5);
        queue_op(MODE_CP, 16'h0042, 16'h0042);
        queue_op(MODE_CP, 16'h0010, 16'h0020);
        queue_op(MODE_INC8, 16'hFFFF, 16'h0000);
        queue_op(MODE_INC8, 16'h000F, 16'hFFFF);
        queue_op(MODE_DEC8, 16'h0001, 16'h0000);
        queue_op(MODE_DEC8, 16'h0010, 16'h0000);
        queue_op(MODE_ADD16, 16'h0FFF, 16'h0001);
        queue_op(MODE_ADD16, 16'h8000, 16'h8000);
        queue_op(MODE_ADD16, 16'hFFFF, 16'hFFFF);
        queue_op(MODE_ADDSP, 16'hFFF8, 16'h0008);
        queue_op(MODE_ADDSP, 16'h0000, 16'hFF80);
        queue_op(MODE_INC16, 16'hFFFF, 16'h1234);
        queue_op(MODE_DEC16, 16'h0000, 16'h0000);
        queue_op(MODE_RSVD_E, 16'hFFFF, 16'hFFFF);
        queue_op(MODE_RSVD_F, 16'h1234, 16'h5678);

        for (int i = 0; i < RANDOM_OPS; i++) begin
            m = alu_mode_t'($urandom_range(int'(MODE_DEC16)));
            queue_op(m, pick_operand(), pick_operand());
        end
        total_ops = op_queue.size();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (ops_accepted < total_ops / 3) @(negedge aclk);
        send_idle_pct = 54;
        recv_stall_pct = 37;
        while (ops_accepted < (2 * total_ops) / 3) @(negedge aclk);
        send_idle_pct = 0;
        recv_stall_pct = 0;

        while (op_queue.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d operations (all fourteen ALU modes plus both reserved codes),",
                 ops_accepted);
        $display("checked %0d results under three handshake pacing mixes.", results_checked);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
